// ----- rtl/ldags_pkg.sv -----
package ldags_pkg;

    localparam int TOPICS        = 64;
    localparam int VOCAB         = 4096;
    localparam int DOCS          = 256;
    localparam int WORDS_PER_DOC = 256;
    localparam int MAX_PICK      = 64;

    localparam int TW  = $clog2(TOPICS);
    localparam int VW  = $clog2(VOCAB);
    localparam int DW  = $clog2(DOCS);
    localparam int PW  = $clog2(WORDS_PER_DOC);
    localparam int KW  = $clog2(MAX_PICK) + 1;

    localparam int NWA = TW + VW;
    localparam int NDA = DW + TW;
    localparam int WTA = DW + PW;

    localparam int CW17 = 17;
    localparam int CW9  = 9;
    localparam int NUMW = 34;
    localparam int QW   = 32;
    localparam int DQW  = 26;
    localparam int WGW  = 42;
    localparam int SUMW = 48;

    localparam logic [2:0] CFG_ALPHA  = 3'd0;
    localparam logic [2:0] CFG_BETA   = 3'd1;
    localparam logic [2:0] CFG_TOPICS = 3'd2;
    localparam logic [2:0] CFG_VOCAB  = 3'd3;

    typedef struct packed {
        logic cap;
        logic clr;
        logic wt_wr;
        logic k_old;
        logic k_zero;
        logic k_inc;
        logic cnt_dec;
        logic cnt_inc;
        logic sum_clr;
        logic ops;
        logic mul;
        logic acc;
        logic thr;
        logic pick;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic func_in;
        logic div_done;
        logic last;
        logic hit;
        logic out_busy;
    } t_stat;

endpackage

// ----- rtl/ldags_ram.sv -----
module ldags_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ldags_div.sv -----
module ldags_div
    import ldags_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [NUMW-1:0] i_num,
    input  logic [NUMW-1:0] i_den,
    output logic            o_done,
    output logic [QW-1:0]   o_quot
);

    logic            r_busy;
    logic            r_done;
    logic [4:0]      r_cnt;
    logic [NUMW-1:0] r_rem;
    logic [NUMW-1:0] r_den;
    logic [QW-1:0]   r_dvd;
    logic [QW-1:0]   r_q;
    logic [NUMW:0]   n_try;
    logic            n_ge;
    logic [NUMW:0]   n_diff;

    always_comb begin
        n_try  = {r_rem, r_dvd[QW-1]};
        n_ge   = n_try >= {1'b0, r_den};
        n_diff = n_try - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= 5'd31;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {8'd0, i_num[NUMW-1:8]};
            r_dvd <= {i_num[7:0], 24'd0};
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[NUMW-1:0] : n_try[NUMW-1:0];
            r_dvd <= {r_dvd[QW-2:0], 1'b0};
            r_q   <= {r_q[QW-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ----- rtl/ldags_dp.sv -----
module ldags_dp
    import ldags_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [19:0] i_cfg_data,
    input  logic        i_func,
    input  logic [7:0]  i_doc,
    input  logic [7:0]  i_position,
    input  logic [11:0] i_word,
    input  logic [5:0]  i_given_topic,
    input  logic [15:0] i_random_fraction,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_topic
);

    logic [19:0]     r_alpha;
    logic [19:0]     r_beta;
    logic [6:0]      r_topics;
    logic [12:0]     r_vocab;
    logic            r_func;
    logic [DW-1:0]   r_doc;
    logic [PW-1:0]   r_pos;
    logic [VW-1:0]   r_word;
    logic [15:0]     r_rnd;
    logic [TW-1:0]   r_topic;
    logic [TW-1:0]   r_kidx;
    logic [32:0]     r_vbeta;
    logic [NWA-1:0]  r_clr_cnt;
    logic            r_clr_done;
    logic [NUMW-1:0] r_num;
    logic [NUMW-1:0] r_den;
    logic [DQW-1:0]  r_dq;
    logic [WGW-1:0]  r_wgt;
    logic [SUMW-1:0] r_sum;
    logic [SUMW-1:0] r_thr;
    logic            r_ovalid;
    logic [5:0]      r_otopic;

    logic [TW-1:0]   wt_rd;
    logic [CW17-1:0] nw_rd, nt_rd, nw_wd, nt_wd;
    logic [CW9-1:0]  nd_rd, ndt_rd, nd_wd, ndt_wd;
    logic [SUMW-1:0] cw_rd;
    logic            cnt_we, ndt_we;
    logic [NWA-1:0]  nw_addr, nw_waddr;
    logic [NDA-1:0]  nd_addr, nd_waddr;
    logic [TW-1:0]   nt_waddr;
    logic [DW-1:0]   ndt_waddr;
    logic [NUMW-1:0] n_num, n_den;
    logic            div_done;
    logic [QW-1:0]   quot;
    logic [QW-1:0]   n_ratio;
    logic            n_sat;
    logic [57:0]     n_prod;
    logic [SUMW:0]   n_add;
    logic [SUMW-1:0] n_sum;
    logic [63:0]     n_thr;
    logic [KW-1:0]   n_klim;

    function automatic logic [CW17-1:0] f_upd17(input logic [CW17-1:0] v, input logic dec);
        logic [CW17-1:0] r;
        r = v;
        if (dec) begin
            if (v != '0) r = v - 1'b1;
        end else if (v != '1) begin
            r = v + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [CW9-1:0] f_upd9(input logic [CW9-1:0] v, input logic dec);
        logic [CW9-1:0] r;
        r = v;
        if (dec) begin
            if (v != '0) r = v - 1'b1;
        end else if (v != '1) begin
            r = v + 1'b1;
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= 20'd655;
            r_beta   <= 20'd6554;
            r_topics <= 7'd40;
            r_vocab  <= 13'd4096;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ALPHA:  r_alpha  <= i_cfg_data;
                CFG_BETA:   r_beta   <= i_cfg_data;
                CFG_TOPICS: r_topics <= i_cfg_data[6:0];
                CFG_VOCAB:  r_vocab  <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt  <= '0;
            r_clr_done <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cmd.clr && !r_clr_done) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == '1) begin
                    r_clr_done <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_klim = (r_topics == '0) ? KW'(1) :
                 (r_topics > KW'(MAX_PICK)) ? KW'(MAX_PICK) : r_topics;
        n_num  = {1'b0, nw_rd, 16'd0} + NUMW'(r_beta);
        n_den  = {1'b0, nt_rd, 16'd0} + NUMW'(r_vbeta);
        n_sat  = {8'd0, r_num} >= {r_den, 8'd0};
        n_ratio = (r_den == '0) ? '0 : (n_sat ? '1 : quot);
        n_prod = n_ratio * r_dq;
        n_add  = {1'b0, r_sum} + (SUMW + 1)'(r_wgt);
        n_sum  = n_add[SUMW] ? '1 : n_add[SUMW-1:0];
        n_thr  = r_rnd * r_sum;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_func  <= i_func;
            r_doc   <= i_doc[DW-1:0];
            r_pos   <= i_position[PW-1:0];
            r_word  <= i_word[VW-1:0];
            r_rnd   <= i_random_fraction;
            r_topic <= i_given_topic[TW-1:0];
            r_vbeta <= r_vocab * r_beta;
        end else if (i_cmd.pick) begin
            r_topic <= r_kidx;
        end
        if (i_cmd.cap) begin
            r_kidx <= i_given_topic[TW-1:0];
        end else if (i_cmd.k_old) begin
            r_kidx <= wt_rd;
        end else if (i_cmd.k_zero) begin
            r_kidx <= '0;
        end else if (i_cmd.k_inc) begin
            r_kidx <= r_kidx + 1'b1;
        end
        if (i_cmd.ops) begin
            r_num <= n_num;
            r_den <= n_den;
            r_dq  <= {1'b0, nd_rd, 16'd0} + DQW'(r_alpha);
        end
        if (i_cmd.mul) begin
            r_wgt <= n_prod[57:16];
        end
        if (i_cmd.sum_clr) begin
            r_sum <= '0;
        end else if (i_cmd.acc) begin
            r_sum <= n_sum;
        end
        if (i_cmd.thr) begin
            r_thr <= n_thr[63:16];
        end
        if (i_cmd.out_load) begin
            r_otopic <= 6'(r_topic);
        end
    end

    always_comb begin
        nw_addr   = {r_kidx, r_word};
        nd_addr   = {r_doc, r_kidx};
        cnt_we    = i_cmd.clr | i_cmd.cnt_dec | i_cmd.cnt_inc;
        ndt_we    = i_cmd.clr | (i_cmd.cnt_inc & ~r_func);
        nw_waddr  = i_cmd.clr ? r_clr_cnt : nw_addr;
        nd_waddr  = i_cmd.clr ? r_clr_cnt[NDA-1:0] : nd_addr;
        nt_waddr  = i_cmd.clr ? r_clr_cnt[TW-1:0] : r_kidx;
        ndt_waddr = i_cmd.clr ? r_clr_cnt[DW-1:0] : r_doc;
        nw_wd     = i_cmd.clr ? '0 : f_upd17(nw_rd, i_cmd.cnt_dec);
        nt_wd     = i_cmd.clr ? '0 : f_upd17(nt_rd, i_cmd.cnt_dec);
        nd_wd     = i_cmd.clr ? '0 : f_upd9(nd_rd, i_cmd.cnt_dec);
        ndt_wd    = i_cmd.clr ? '0 : f_upd9(ndt_rd, 1'b0);
    end

    ldags_ram #(.WIDTH(TW), .DEPTH(DOCS * WORDS_PER_DOC)) u_wt (
        .i_clk(i_clk), .i_we(i_cmd.wt_wr), .i_waddr({r_doc, r_pos}), .i_wdata(r_topic),
        .i_raddr({r_doc, r_pos}), .o_rdata(wt_rd)
    );

    ldags_ram #(.WIDTH(CW17), .DEPTH(TOPICS * VOCAB)) u_nw (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(nw_waddr), .i_wdata(nw_wd),
        .i_raddr(nw_addr), .o_rdata(nw_rd)
    );

    ldags_ram #(.WIDTH(CW9), .DEPTH(DOCS * TOPICS)) u_nd (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(nd_waddr), .i_wdata(nd_wd),
        .i_raddr(nd_addr), .o_rdata(nd_rd)
    );

    ldags_ram #(.WIDTH(CW17), .DEPTH(TOPICS)) u_nt (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(nt_waddr), .i_wdata(nt_wd),
        .i_raddr(r_kidx), .o_rdata(nt_rd)
    );

    ldags_ram #(.WIDTH(CW9), .DEPTH(DOCS)) u_ndt (
        .i_clk(i_clk), .i_we(ndt_we), .i_waddr(ndt_waddr), .i_wdata(ndt_wd),
        .i_raddr(r_doc), .o_rdata(ndt_rd)
    );

    ldags_ram #(.WIDTH(SUMW), .DEPTH(TOPICS)) u_cw (
        .i_clk(i_clk), .i_we(i_cmd.acc), .i_waddr(r_kidx), .i_wdata(n_sum),
        .i_raddr(r_kidx), .o_rdata(cw_rd)
    );

    ldags_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.ops), .i_num(n_num),
        .i_den(n_den), .o_done(div_done), .o_quot(quot)
    );

    always_comb begin
        o_stat.clr_done = r_clr_done;
        o_stat.func_in  = i_func;
        o_stat.div_done = div_done;
        o_stat.last     = KW'(r_kidx) == n_klim - 1'b1;
        o_stat.hit      = cw_rd > r_thr;
        o_stat.out_busy = r_ovalid & ~i_out_ready;
    end

    assign o_out_valid = r_ovalid;
    assign o_topic     = r_otopic;

endmodule

// ----- rtl/ldags_ctrl.sv -----
module ldags_ctrl
    import ldags_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_RS_RD  = 4'd2;
    localparam logic [3:0] S_RS_OLD = 4'd3;
    localparam logic [3:0] S_RS_CRD = 4'd4;
    localparam logic [3:0] S_RS_DEC = 4'd5;
    localparam logic [3:0] S_W_RD   = 4'd6;
    localparam logic [3:0] S_W_OPS  = 4'd7;
    localparam logic [3:0] S_W_DIV  = 4'd8;
    localparam logic [3:0] S_W_MUL  = 4'd9;
    localparam logic [3:0] S_W_ACC  = 4'd10;
    localparam logic [3:0] S_THR    = 4'd11;
    localparam logic [3:0] S_S_RD   = 4'd12;
    localparam logic [3:0] S_S_CMP  = 4'd13;
    localparam logic [3:0] S_ADD_RD = 4'd14;
    localparam logic [3:0] S_ADD_WR = 4'd15;

    logic [3:0] r_state, n_state;
    logic       r_out_pend, n_out_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_out_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_out_pend <= n_out_pend;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_out_pend = r_out_pend;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        if (r_out_pend && !i_stat.out_busy) begin
            o_cmd.out_load = 1'b1;
            n_out_pend     = 1'b0;
        end
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = !r_out_pend;
                if (i_in_valid && !r_out_pend) begin
                    o_cmd.cap = 1'b1;
                    n_state   = i_stat.func_in ? S_RS_RD : S_ADD_RD;
                end
            end
            S_RS_RD:  n_state = S_RS_OLD;
            S_RS_OLD: begin
                o_cmd.k_old = 1'b1;
                n_state     = S_RS_CRD;
            end
            S_RS_CRD: n_state = S_RS_DEC;
            S_RS_DEC: begin
                o_cmd.cnt_dec = 1'b1;
                o_cmd.k_zero  = 1'b1;
                o_cmd.sum_clr = 1'b1;
                n_state       = S_W_RD;
            end
            S_W_RD:  n_state = S_W_OPS;
            S_W_OPS: begin
                o_cmd.ops = 1'b1;
                n_state   = S_W_DIV;
            end
            S_W_DIV: if (i_stat.div_done) n_state = S_W_MUL;
            S_W_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_W_ACC;
            end
            S_W_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_stat.last) begin
                    n_state = S_THR;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_W_RD;
                end
            end
            S_THR: begin
                o_cmd.thr    = 1'b1;
                o_cmd.k_zero = 1'b1;
                n_state      = S_S_RD;
            end
            S_S_RD: n_state = S_S_CMP;
            S_S_CMP: begin
                if (i_stat.hit || i_stat.last) begin
                    o_cmd.pick = 1'b1;
                    n_state    = S_ADD_RD;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_S_RD;
                end
            end
            S_ADD_RD: n_state = S_ADD_WR;
            S_ADD_WR: begin
                o_cmd.cnt_inc = 1'b1;
                o_cmd.wt_wr   = 1'b1;
                n_out_pend    = 1'b1;
                n_state       = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_ready_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> i_stat.clr_done)
        else $error("input taken before clearing pass finished");

    a_load_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_stat.out_busy)
        else $error("result written over pending result");

    a_div_follows_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_W_OPS |=> r_state == S_W_DIV && !i_stat.div_done)
        else $error("divider done not cleared on start");

    a_no_dec_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cnt_dec |=> !o_cmd.cnt_inc && !o_cmd.clr)
        else $error("count update overlap");

endmodule

// ----- rtl/lda_gibbs_topic_sampler_top.sv -----
// load: the given topic is stored and its counts are raised, then it goes out as the result
// resample: reads and removes the old topic, weighs each of the K topics in use, then picks
// the per-topic weights come from the 32-step radix-2 divider shared over topics
// result sits in an output register; a new input is taken once it has moved on
// after reset a clearing pass zeroes the count memories
// no input is taken during the clearing pass; config writes are taken throughout
module lda_gibbs_topic_sampler_top
    import ldags_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [19:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [7:0]  i_doc,
    input  logic [7:0]  i_position,
    input  logic [11:0] i_word,
    input  logic [5:0]  i_given_topic,
    input  logic [15:0] i_random_fraction,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_topic
);

    t_cmd  cmd;
    t_stat stat;

    ldags_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .i_stat(stat), .o_cmd(cmd)
    );

    ldags_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_func(i_func), .i_doc(i_doc), .i_position(i_position), .i_word(i_word),
        .i_given_topic(i_given_topic), .i_random_fraction(i_random_fraction),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_topic(o_topic)
    );

endmodule

// ----- tb/tb_lda_gibbs_topic_sampler_top.sv -----
`timescale 1ns / 1ps

module tb_lda_gibbs_topic_sampler_top;
    import ldags_pkg::*;

    localparam logic FN_LOAD     = 1'b0;
    localparam logic FN_RESAMPLE = 1'b1;
    localparam logic [2:0] CFG_SPARE = 3'd7;
    localparam int CYCLE_LIMIT = 20000000;
    localparam logic [63:0] RATIO_SAT = 64'hFFFF_FFFF;
    localparam logic [63:0] SUM_SAT   = 64'hFFFF_FFFF_FFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [19:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_func = 1'b0;
    logic [7:0]  i_doc = '0;
    logic [7:0]  i_position = '0;
    logic [11:0] i_word = '0;
    logic [5:0]  i_given_topic = '0;
    logic [15:0] i_random_fraction = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [5:0]  o_topic;

    lda_gibbs_topic_sampler_top dut (.*);

    always #5 i_clk = ~i_clk;

    // sampler mirror
    int unsigned tw_cnt[int];
    int unsigned dt_cnt[int];
    int unsigned tot_cnt[64];
    bit [5:0]    occ_topic[int];
    bit [11:0]   occ_word[int];
    int          occ_keys[$];
    bit [19:0]   m_alpha = 20'd655;
    bit [19:0]   m_beta = 20'd6554;
    bit [6:0]    m_topics = 7'd40;
    bit [12:0]   m_vocab = 13'd4096;

    bit [5:0] topic_exp_q[$];
    int errors = 0;
    int n_load = 0;
    int n_resample = 0;
    int n_checked = 0;
    int cycles = 0;
    bit calm = 1'b0;
    bit pressure_req = 1'b0;
    bit pressure_done = 1'b0;
    int stall_left = 0;

    function automatic void cnt_inc(ref int unsigned a[int], input int key, input int unsigned lim);
        int unsigned v;
        v = a.exists(key) ? a[key] : 0;
        if (v < lim) a[key] = v + 1;
    endfunction

    function automatic void cnt_dec(ref int unsigned a[int], input int key);
        if (a.exists(key) && a[key] > 0) a[key] = a[key] - 1;
    endfunction

    function automatic void add_topic(int d, int w, int t);
        cnt_inc(tw_cnt, t * VOCAB + w, 131071);
        cnt_inc(dt_cnt, d * TOPICS + t, 511);
        if (tot_cnt[t] < 131071) tot_cnt[t]++;
    endfunction

    function automatic bit [5:0] draw_topic(int d, int w, int old, bit [15:0] rnd);
        int kc;
        int k;
        bit [63:0] vbeta;
        bit [63:0] num;
        bit [63:0] den;
        bit [63:0] ratio;
        bit [63:0] dq;
        bit [63:0] sum;
        bit [63:0] thr;
        bit [63:0] cum[64];
        kc = (m_topics < 1) ? 1 : (m_topics > 64 ? 64 : int'(m_topics));
        vbeta = 64'(m_vocab) * 64'(m_beta);
        cnt_dec(tw_cnt, old * VOCAB + w);
        cnt_dec(dt_cnt, d * TOPICS + old);
        if (tot_cnt[old] > 0) tot_cnt[old]--;
        sum = 0;
        for (k = 0; k < kc; k++) begin
            num = ((tw_cnt.exists(k * VOCAB + w) ? 64'(tw_cnt[k * VOCAB + w]) : 64'd0) << 16)
                  + 64'(m_beta);
            den = (64'(tot_cnt[k]) << 16) + vbeta;
            dq = ((dt_cnt.exists(d * TOPICS + k) ? 64'(dt_cnt[d * TOPICS + k]) : 64'd0) << 16)
                 + 64'(m_alpha);
            ratio = 0;
            if (den != 0) begin
                ratio = (num << 24) / den;
                if (ratio > RATIO_SAT) ratio = RATIO_SAT;
            end
            sum = sum + ((ratio * dq) >> 16);
            if (sum > SUM_SAT) sum = SUM_SAT;
            cum[k] = sum;
        end
        thr = (64'(rnd) * sum) >> 16;
        for (k = 0; k < kc; k++) begin
            if (cum[k] > thr) break;
        end
        if (k == kc) k = kc - 1;
        return 6'(k);
    endfunction

    function automatic bit [5:0] predict_topic(bit fn, bit [7:0] d, bit [7:0] p, bit [11:0] w,
                                               bit [5:0] given, bit [15:0] rnd);
        int slot;
        bit [5:0] t;
        slot = {d, p};
        if (fn == FN_LOAD) begin
            t = given;
            if (!occ_topic.exists(slot)) occ_keys.push_back(slot);
            occ_topic[slot] = t;
            occ_word[slot] = w;
            add_topic(d, w, t);
        end else begin
            t = draw_topic(d, w, occ_topic[slot], rnd);
            add_topic(d, w, t);
            occ_topic[slot] = t;
        end
        return t;
    endfunction

    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(20, 150);
    endfunction

    task automatic cfg_write(bit [2:0] idx, bit [19:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_ALPHA:  m_alpha = val;
            CFG_BETA:   m_beta = val;
            CFG_TOPICS: m_topics = val[6:0];
            CFG_VOCAB:  m_vocab = val[12:0];
            default: ;
        endcase
    endtask

    task automatic configure(bit [19:0] a, bit [19:0] b, bit [19:0] k, bit [19:0] v);
        cfg_write(CFG_ALPHA, a);
        cfg_write(CFG_BETA, b);
        cfg_write(CFG_TOPICS, k);
        cfg_write(CFG_VOCAB, v);
        cfg_write(CFG_SPARE, 20'(~a));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (topic_exp_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_item(bit fn, bit [7:0] d, bit [7:0] p, bit [11:0] w, bit [5:0] g,
                             bit [15:0] rnd, bit known, bit [5:0] want);
        int gap;
        bit [5:0] t;
        i_in_valid <= 1'b1;
        i_func <= fn;
        i_doc <= d;
        i_position <= p;
        i_word <= w;
        i_given_topic <= g;
        i_random_fraction <= rnd;
        do @(posedge i_clk); while (!o_in_ready);
        t = predict_topic(fn, d, p, w, g, rnd);
        if (known && t != want) begin
            $error("topic mismatch on directed row: expected %0d actual %0d", want, t);
            errors++;
        end
        topic_exp_q.push_back(known ? want : t);
        if (fn == FN_LOAD) n_load++; else n_resample++;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic rand_item(int load_pct, int doc_span, int word_span);
        int r;
        int slot;
        bit [7:0] d;
        bit [11:0] w;
        r = $urandom_range(0, 99);
        if (occ_keys.size() == 0 || r < load_pct) begin
            if ($urandom_range(0, 9) == 0) begin
                d = 8'($urandom);
                w = 12'($urandom);
            end else begin
                d = 8'($urandom_range(0, doc_span));
                w = 12'($urandom_range(0, word_span));
            end
            send_item(FN_LOAD, d, 8'($urandom), w, 6'($urandom), 16'($urandom), 0, 0);
        end else begin
            slot = occ_keys[$urandom_range(0, occ_keys.size() - 1)];
            w = ($urandom_range(0, 9) == 0) ? 12'($urandom) : occ_word[slot];
            send_item(FN_RESAMPLE, 8'(slot >> 8), 8'(slot), w, 6'($urandom),
                      16'($urandom), 0, 0);
        end
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        int r;
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (pressure_req && !pressure_done) begin
            pressure_done = 1'b1;
            i_out_ready <= 1'b0;
            stall_left <= 6000;
        end else if (calm) begin
            i_out_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b0;
                stall_left <= (r < 97) ? $urandom_range(0, 3) : $urandom_range(20, 200);
            end
        end
    end

    always @(posedge i_clk) begin
        bit [5:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (topic_exp_q.size() == 0) begin
                $error("result transfer with nothing expected: topic %0d", o_topic);
                errors++;
            end else begin
                want = topic_exp_q.pop_front();
                n_checked++;
                if (o_topic !== want) begin
                    $error("topic mismatch: expected %0d actual %0d", want, o_topic);
                    errors++;
                end
            end
        end
    end

    typedef struct {
        bit        fn;
        bit [7:0]  d;
        bit [7:0]  p;
        bit [11:0] w;
        bit [5:0]  g;
        bit [15:0] rnd;
        bit        known;
        bit [5:0]  want;
    } row_t;

    row_t rows[11] = '{
        '{FN_LOAD,     8'd0,   8'd0,   12'd0,    6'd0,  16'd0,     1, 6'd0},
        '{FN_LOAD,     8'd255, 8'd255, 12'd4095, 6'd63, 16'd65535, 1, 6'd63},
        '{FN_LOAD,     8'd1,   8'd2,   12'd3,    6'd39, 16'd100,   1, 6'd39},
        '{FN_RESAMPLE, 8'd0,   8'd0,   12'd0,    6'd63, 16'd0,     0, 6'd0},
        '{FN_RESAMPLE, 8'd255, 8'd255, 12'd4095, 6'd0,  16'd65535, 0, 6'd0},
        '{FN_RESAMPLE, 8'd1,   8'd2,   12'd3,    6'd5,  16'd32768, 0, 6'd0},
        '{FN_LOAD,     8'd0,   8'd0,   12'd0,    6'd7,  16'd1,     1, 6'd7},
        '{FN_RESAMPLE, 8'd0,   8'd0,   12'd0,    6'd42, 16'd12345, 0, 6'd0},
        '{FN_LOAD,     8'd17,  8'd99,  12'd2048, 6'd21, 16'd4,     1, 6'd21},
        '{FN_RESAMPLE, 8'd17,  8'd99,  12'd2048, 6'd1,  16'd65535, 0, 6'd0},
        '{FN_RESAMPLE, 8'd17,  8'd99,  12'd1,    6'd2,  16'd0,     0, 6'd0}
    };

    initial begin
        int i;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < 11; i++)
            send_item(rows[i].fn, rows[i].d, rows[i].p, rows[i].w, rows[i].g, rows[i].rnd,
                      rows[i].known, rows[i].want);
        i_in_valid <= 1'b0;
        drain();

        configure(20'd655, 20'd6554, 20'($urandom_range(1, 16)), 20'd4096);
        pressure_req = 1'b1;
        for (i = 0; i < 200; i++) rand_item(40, 7, 31);
        i_in_valid <= 1'b0;
        drain();

        // zero beta and vocab: empty topics divide by zero
        configure(20'd0, 20'd0, 20'd64, 20'd0);
        for (i = 0; i < 100; i++) rand_item(35, 7, 31);
        i_in_valid <= 1'b0;
        drain();

        configure(20'hFFFFF, 20'hFFFFF, 20'd0, 20'h1FFF);
        for (i = 0; i < 100; i++) rand_item(40, 255, 4095);
        i_in_valid <= 1'b0;
        drain();

        // pile one doc onto one topic past the 9-bit count limit
        calm = 1'b1;
        configure(20'd65536, 20'd6554, 20'd2, 20'd100);
        for (i = 0; i < 515; i++)
            send_item(FN_LOAD, 8'd3, 8'($urandom), 12'd9, 6'd1, 16'($urandom), 1, 6'd1);
        for (i = 0; i < 50; i++) rand_item(0, 3, 9);
        i_in_valid <= 1'b0;
        drain();
        calm = 1'b0;

        configure(20'd3000, 20'd100, 20'd127, 20'd1);
        for (i = 0; i < 194; i++) rand_item(35, 15, 63);
        i_in_valid <= 1'b0;
        drain();
        repeat (50) @(posedge i_clk);

        if (topic_exp_q.size() != 0) begin
            $error("%0d expected topics never arrived", topic_exp_q.size());
            errors++;
        end
        $display("covered %0d loads and %0d resamples over six register settings",
                 n_load, n_resample);
        $display("%0d topic results checked, %0d occurrences placed", n_checked,
                 occ_keys.size());
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ldags_pkg.sv
rtl/ldags_ram.sv
rtl/ldags_div.sv
rtl/ldags_dp.sv
rtl/ldags_ctrl.sv
rtl/lda_gibbs_topic_sampler_top.sv
tb/tb_lda_gibbs_topic_sampler_top.sv
